FILE: hw/rtl/rtc_pkg.sv
`timescale 1ns / 1ps

package rtc_pkg;

    localparam int VALUE_BITS = 32;

    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int BIN_DIGITS = VALUE_BITS;
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int TXT_W      = (BCD_W > VALUE_BITS) ? BCD_W : VALUE_BITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] IN_HEX = 2'd0;
    localparam logic [1:0] IN_BIN = 2'd1;

    localparam logic [1:0] OUT_DEC = 2'd0;
    localparam logic [1:0] OUT_BIN = 2'd1;
    localparam logic [1:0] OUT_HEX = 2'd2;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_A_BIAS = 8'h57;

    typedef struct packed {
        logic [7:0] digit_char;
        logic [1:0] source_base;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] out_base;
        logic       end_of_text;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dab_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CSTART,
        S_CWAIT,
        S_LOAD,
        S_EMIT
    } t_state;

endpackage

FILE: hw/rtl/rtc_dabble.sv
`timescale 1ns / 1ps

module rtc_dabble (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rtc_pkg::VALUE_BITS-1:0] i_value,
    output logic [rtc_pkg::BCD_W-1:0]      o_bcd,
    output rtc_pkg::t_dab_stat             o_stat
);
    import rtc_pkg::*;

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BCD_W-1:0]      corr;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    // add-3 on every BCD digit of 5 or more, before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                corr[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                corr[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = CNT_W'(VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {corr[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_bcd       = r_bcd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hw/rtl/radix_text_converter.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Word
// in      | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
// out     | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//
// A character that is not the last is folded into the value; input stays ready.
// On the last character: a serial BCD conversion runs first when a decimal
// text is due (S_CSTART, S_CWAIT); then each text is loaded in S_LOAD and
// emitted digit by digit in S_EMIT, leading zero digits stepped over there
// without output. Input is taken only between numbers.
// Synchronous active-low reset clears the value and control state but not r_kind.
// A stalled output word holds, and digit emission waits with it.

module radix_text_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rtc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rtc_pkg::t_out_word o_out_word
);
    import rtc_pkg::*;

    function automatic logic [3:0] digit_val(input logic [7:0] ch, input logic [1:0] base);
        logic [4:0] d;
        logic [4:0] radix;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = 5'(ch - CH_ZERO);
        end else if (ch >= CH_A && ch <= CH_F) begin
            d = 5'(ch - CH_A_BIAS);
        end else begin
            d = 5'd16;
        end
        if (base == IN_HEX) begin
            radix = 5'd16;
        end else if (base == IN_BIN) begin
            radix = 5'd2;
        end else begin
            radix = 5'd10;
        end
        return (d < radix) ? d[3:0] : 4'd0;
    endfunction

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [1:0]            r_base, n_base;
    logic                  r_second, n_second;
    logic [1:0]            r_kind, n_kind;
    logic [TXT_W-1:0]      r_txt, n_txt;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic                  r_started, n_started;
    logic                  r_ov, n_ov;
    t_out_word             r_ow, n_ow;

    logic                  dab_start;
    logic [BCD_W-1:0]      dab_bcd;
    t_dab_stat             dab_stat;

    logic [VALUE_BITS-1:0] acc_step;
    logic [3:0]            in_digit;
    logic [3:0]            cur_digit;
    logic [7:0]            cur_char;
    logic [TXT_W-1:0]      txt_shift;
    logic                  show;
    logic                  out_free;

    rtc_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_value (r_acc),
        .o_bcd   (dab_bcd),
        .o_stat  (dab_stat)
    );

    always_comb begin
        in_digit = digit_val(i_in_word.digit_char, i_in_word.source_base);
        if (i_in_word.source_base == IN_HEX) begin
            acc_step = (r_acc << 4) + VALUE_BITS'(in_digit);
        end else if (i_in_word.source_base == IN_BIN) begin
            acc_step = (r_acc << 1) + VALUE_BITS'(in_digit);
        end else begin
            acc_step = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(in_digit);
        end
    end

    always_comb begin
        if (r_kind == OUT_BIN) begin
            cur_digit = {3'b000, r_txt[TXT_W-1]};
            txt_shift = r_txt << 1;
        end else begin
            cur_digit = r_txt[TXT_W-1 -: 4];
            txt_shift = r_txt << 4;
        end
        if (cur_digit < 4'd10) begin
            cur_char = CH_ZERO + {4'h0, cur_digit};
        end else begin
            cur_char = CH_A_BIAS + {4'h0, cur_digit};
        end
    end

    assign show     = r_started || (cur_digit != 4'd0) || (r_rem == CNT_W'(1));
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_base    = r_base;
        n_second  = r_second;
        n_kind    = r_kind;
        n_txt     = r_txt;
        n_rem     = r_rem;
        n_started = r_started;
        n_ov      = r_ov && !i_out_ready;
        n_ow      = r_ow;
        dab_start = 1'b0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_acc  = acc_step;
                    n_base = i_in_word.source_base;
                    if (i_in_word.last_char) begin
                        n_second = 1'b0;
                        if (i_in_word.source_base == IN_HEX ||
                            i_in_word.source_base == IN_BIN) begin
                            n_state = S_CSTART;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_CSTART: begin
                dab_start = 1'b1;
                n_state   = S_CWAIT;
            end
            S_CWAIT: begin
                if (dab_stat.done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_started = 1'b0;
                n_state   = S_EMIT;
                if (!r_second && (r_base == IN_HEX || r_base == IN_BIN)) begin
                    n_kind = OUT_DEC;
                    n_txt  = TXT_W'(dab_bcd) << (TXT_W - BCD_W);
                    n_rem  = CNT_W'(DEC_DIGITS);
                end else if ((!r_second) || (r_base == IN_BIN)) begin
                    n_kind = OUT_HEX;
                    n_txt  = TXT_W'(r_acc) << (TXT_W - HEX_DIGITS * 4);
                    n_rem  = CNT_W'(HEX_DIGITS);
                end else begin
                    n_kind = OUT_BIN;
                    n_txt  = TXT_W'(r_acc) << (TXT_W - BIN_DIGITS);
                    n_rem  = CNT_W'(BIN_DIGITS);
                end
            end
            S_EMIT: begin
                if (!show) begin
                    n_txt = txt_shift;
                    n_rem = r_rem - 1'b1;
                end else if (out_free) begin
                    n_ov             = 1'b1;
                    n_ow.out_char    = cur_char;
                    n_ow.out_base    = r_kind;
                    n_ow.end_of_text = (r_rem == CNT_W'(1));
                    n_ow.last        = (r_rem == CNT_W'(1)) && r_second;
                    n_txt            = txt_shift;
                    n_rem            = r_rem - 1'b1;
                    n_started        = 1'b1;
                    if (r_rem == CNT_W'(1)) begin
                        if (r_second) begin
                            n_acc   = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_second = 1'b1;
                            n_state  = S_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_base    <= IN_HEX;
            r_second  <= 1'b0;
            r_rem     <= '0;
            r_started <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_base    <= n_base;
            r_second  <= n_second;
            r_rem     <= n_rem;
            r_started <= n_started;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_txt  <= n_txt;
        r_ow   <= n_ow;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

endmodule

FILE: hw/rtl/rtc_checker.sv
`timescale 1ns / 1ps

module rtc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rtc_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rtc_pkg::t_out_word o_out_word
);
    import rtc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_last_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last |-> o_out_word.end_of_text)
        else $error("final word not at end of a text");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.last_char |=> !o_in_ready)
        else $error("input taken right after the last character");

    a_char_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.out_char >= CH_ZERO && o_out_word.out_char <= CH_NINE) ||
                        (o_out_word.out_char >= CH_A && o_out_word.out_char <= CH_F))
        else $error("output character is not a digit");

    a_bin_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_base == OUT_BIN |->
            o_out_word.out_char == CH_ZERO || o_out_word.out_char == CH_ONE)
        else $error("binary text holds a non-binary digit");

endmodule

bind radix_text_converter rtc_checker u_rtc_checker (.*);
